/* hw/rtl/rcf_pkg.sv */
// Shared types and constants for the RGB color cycle fader.
// No dependencies; used by every module under hw/rtl.
package rcf_pkg;

    localparam int LEVEL_W = 10;
    localparam int RATE_W  = 12;
    localparam int TIME_W  = 12;
    // ramp_rate * elapsed_time / 1024 fits 14 bits
    localparam int MOVE_W  = RATE_W + TIME_W - 10;
    localparam int SUM_W   = MOVE_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [LEVEL_W-1:0] UPPER_RST = 10'd972;
    localparam logic [LEVEL_W-1:0] LOWER_RST = 10'd102;
    localparam logic [RATE_W-1:0]  RATE_RST  = 12'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_LEVEL = 2'd0,
        CFG_LOWER_LEVEL = 2'd1,
        CFG_RAMP_RATE   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'd0,
        PH_G_UP  = 3'd1,
        PH_B_DN  = 3'd2,
        PH_R_UP  = 3'd3,
        PH_G_DN  = 3'd4,
        PH_B_UP  = 3'd5,
        PH_G_UP2 = 3'd6,
        PH_RG_DN = 3'd7
    } phase_t;

    typedef struct packed {
        logic [RATE_W-1:0]  ramp_rate;
        logic [LEVEL_W-1:0] lower_level;
        logic [LEVEL_W-1:0] upper_level;
    } cfg_t;

    // blue in the top bits, red in the low bits
    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } color_t;

endpackage

/* hw/rtl/rcf_cfg_regs.sv */
// Configuration register bank of the color fader.
// Depends on rcf_pkg.
module rcf_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rcf_pkg::cfg_t                    cfg
);

    rcf_pkg::cfg_t cfg_reg;
    rcf_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rcf_pkg::CFG_UPPER_LEVEL:
                    cfg_next.upper_level = cfg_data[rcf_pkg::LEVEL_W-1:0];
                rcf_pkg::CFG_LOWER_LEVEL:
                    cfg_next.lower_level = cfg_data[rcf_pkg::LEVEL_W-1:0];
                rcf_pkg::CFG_RAMP_RATE:
                    cfg_next.ramp_rate = cfg_data[rcf_pkg::RATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_level <= rcf_pkg::UPPER_RST;
            cfg_reg.lower_level <= rcf_pkg::LOWER_RST;
            cfg_reg.ramp_rate   <= rcf_pkg::RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/rcf_fade_core.sv */
// Phase sequencer and color register of the fader; one ramp step per advance.
// Depends on rcf_pkg.
module rcf_fade_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [rcf_pkg::MOVE_W-1:0]    move,
    input  rcf_pkg::cfg_t                 cfg,
    output rcf_pkg::color_t               color
);

    rcf_pkg::phase_t phase_reg;
    rcf_pkg::phase_t phase_next;
    rcf_pkg::color_t color_reg;
    rcf_pkg::color_t color_next;

    logic [rcf_pkg::LEVEL_W-1:0] u;
    logic [rcf_pkg::LEVEL_W-1:0] l;
    logic [rcf_pkg::LEVEL_W-1:0] src;
    logic [rcf_pkg::SUM_W-1:0]   sum_up;
    logic [rcf_pkg::SUM_W-1:0]   dn_bound;
    logic [rcf_pkg::LEVEL_W-1:0] diff_dn;
    logic                        pass_up;
    logic                        pass_dn;

    assign u = cfg.upper_level;
    assign l = cfg.lower_level;

    // channel being ramped in this phase
    always_comb
    begin
        unique case (phase_reg) inside
            rcf_pkg::PH_R_UP, rcf_pkg::PH_RG_DN: src = color_reg.red;
            rcf_pkg::PH_B_DN, rcf_pkg::PH_B_UP:  src = color_reg.blue;
            default:                             src = color_reg.green;
        endcase
    end

    assign sum_up   = rcf_pkg::SUM_W'(src) + rcf_pkg::SUM_W'(move);
    assign pass_up  = sum_up > rcf_pkg::SUM_W'(u);
    // src - move < l, kept unsigned
    assign dn_bound = rcf_pkg::SUM_W'(move) + rcf_pkg::SUM_W'(l);
    assign pass_dn  = rcf_pkg::SUM_W'(src) < dn_bound;
    assign diff_dn  = src - move[rcf_pkg::LEVEL_W-1:0];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            rcf_pkg::PH_LOAD:  phase_next = rcf_pkg::PH_G_UP;
            rcf_pkg::PH_G_UP:  if (pass_up) phase_next = rcf_pkg::PH_B_DN;
            rcf_pkg::PH_B_DN:  if (pass_dn) phase_next = rcf_pkg::PH_R_UP;
            rcf_pkg::PH_R_UP:  if (pass_up) phase_next = rcf_pkg::PH_G_DN;
            rcf_pkg::PH_G_DN:  if (pass_dn) phase_next = rcf_pkg::PH_B_UP;
            rcf_pkg::PH_B_UP:  if (pass_up) phase_next = rcf_pkg::PH_G_UP2;
            rcf_pkg::PH_G_UP2: if (pass_up) phase_next = rcf_pkg::PH_RG_DN;
            rcf_pkg::PH_RG_DN: if (pass_dn) phase_next = rcf_pkg::PH_G_UP;
            default:           phase_next = rcf_pkg::PH_LOAD;
        endcase
    end

    // color written by each phase; fixed channels are reloaded every step
    always_comb
    begin
        color_next = color_reg;
        unique case (phase_reg)
            rcf_pkg::PH_LOAD:
                color_next = '{blue: u, green: l, red: l};
            rcf_pkg::PH_G_UP:
                color_next = '{blue: u, green: pass_up ? u : sum_up[rcf_pkg::LEVEL_W-1:0],
                               red: l};
            rcf_pkg::PH_B_DN:
                color_next = '{blue: pass_dn ? l : diff_dn, green: u, red: l};
            rcf_pkg::PH_R_UP:
                color_next = '{blue: l, green: u,
                               red: pass_up ? u : sum_up[rcf_pkg::LEVEL_W-1:0]};
            rcf_pkg::PH_G_DN:
                color_next = '{blue: l, green: pass_dn ? l : diff_dn, red: u};
            rcf_pkg::PH_B_UP:
                color_next = '{blue: pass_up ? u : sum_up[rcf_pkg::LEVEL_W-1:0],
                               green: l, red: u};
            rcf_pkg::PH_G_UP2:
                color_next = '{blue: u, green: pass_up ? u : sum_up[rcf_pkg::LEVEL_W-1:0],
                               red: u};
            rcf_pkg::PH_RG_DN:
                color_next = '{blue: u, green: pass_dn ? l : diff_dn,
                               red: pass_dn ? l : diff_dn};
            default:
                color_next = color_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rcf_pkg::PH_LOAD;
            color_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

/* hw/rtl/rgb_color_cycle_fader_unit.sv */
// Top level of the RGB color cycle fader: input stage, step multiply, output valid.
// Depends on rcf_pkg, rcf_cfg_regs and rcf_fade_core.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata[11:0] elapsed_time
// m_axis    out        tdata[9:0] red_out, [19:10] green_out, [29:20] blue_out
// cfg       in         cfg_index register, cfg_data value
//
// One input beat accepted per cycle while the output is not stalled.
// The input register holds move = ramp_rate * elapsed_time >> 10; the color
// register is updated from it and doubles as the output data register.
// Reset clears the phase and color to zero; registers return to their defaults.
// An output stall holds the result; one more input beat is held, then s_tready drops.
module rgb_color_cycle_fader_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // [11:0] elapsed_time
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // [9:0] red, [19:10] green, [29:20] blue
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PROD_W = rcf_pkg::RATE_W + rcf_pkg::TIME_W;

    rcf_pkg::cfg_t   cfg;
    rcf_pkg::color_t color;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [rcf_pkg::MOVE_W-1:0]   move_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [PROD_W-1:0]            prod;
    logic                         s_fire;
    logic                         advance;

    rcf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign prod = PROD_W'(cfg.ramp_rate) * PROD_W'(s_tdata[rcf_pkg::TIME_W-1:0]);

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            move_reg <= prod[PROD_W-1:10];
        end
    end

    rcf_fade_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .move    (move_reg),
        .cfg     (cfg),
        .color   (color)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, color};

endmodule
